[rtl/core/bsfm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsfm_pkg;

	localparam int WORD_W = 32;
	localparam int POS_W  = 10;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_RESULT
	} bsfm_state_t;

endpackage

`default_nettype wire

[rtl/core/bsfm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/binary_search_first_match.sv]
// Load: one item per cycle while no search is running, no result.
// Search: the first read of the element RAM is issued with the transfer, then each probe compares
// the returned element and issues the next read (at most ceil(log2(count + 1)) probes, at most
// log2(ARRAY_DEPTH) + 1), then the result is posted; an empty array goes straight to a miss.
// A result waiting on out_stall holds the next search in its result state only.
// Reset clears the count, the FSM and out_valid; the element RAM holds no reset value.
`timescale 1ns / 1ps
`default_nettype none

module binary_search_first_match #(
	parameter int ARRAY_DEPTH = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        mode,
	input  wire logic signed [bsfm_pkg::WORD_W-1:0] value,
	input  wire logic                        start_req,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             found,
	output logic             [bsfm_pkg::POS_W-1:0]  position
);

	import bsfm_pkg::*;

	localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
	localparam int CW = $clog2(ARRAY_DEPTH + 1);

	bsfm_state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     lo_q;
	logic [CW-1:0]     hi_q;     // exclusive upper bound
	logic [AW-1:0]     mid_s1;
	logic [WORD_W-1:0] key_q;
	logic              hit_q;
	logic [AW-1:0]     where_q;
	logic              out_valid_q;
	logic              found_q;
	logic [POS_W-1:0]  pos_q;

	logic              load_acc;
	logic              search_acc;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              load_out;

	logic [CW-1:0]     mid0_w;
	logic              eq_w;
	logic              lt_w;
	logic [CW-1:0]     nlo_w;
	logic [CW-1:0]     nhi_w;
	logic [CW-1:0]     nmid_w;
	logic [POS_W-1:0]  pos_w;

	assign in_stall   = (state_q != ST_IDLE);
	assign load_acc   = in_valid && !in_stall && (mode == MODE_LOAD);
	assign search_acc = in_valid && !in_stall && (mode == MODE_SEARCH);

	// append at the count, or at zero when the array is restarted
	assign wr_en   = load_acc && (start_req || (count_q < CW'(ARRAY_DEPTH)));
	assign wr_addr = start_req ? '0 : count_q[AW-1:0];

	bsfm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ARRAY_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// probe compare and narrowing, then the next midpoint
	assign mid0_w = (count_q - CW'(1)) >> 1;
	assign eq_w   = (rd_data == key_q);
	assign lt_w   = ($signed(key_q) < $signed(rd_data));
	assign nlo_w  = (eq_w || lt_w) ? lo_q : (CW'(mid_s1) + CW'(1));
	assign nhi_w  = (eq_w || lt_w) ? CW'(mid_s1) : hi_q;
	assign nmid_w = nlo_w + ((nhi_w - nlo_w - CW'(1)) >> 1);

	generate
		if (AW >= POS_W) begin : g_pos_trunc
			assign pos_w = where_q[POS_W-1:0];
		end else begin : g_pos_ext
			assign pos_w = {{(POS_W - AW){1'b0}}, where_q};
		end
	endgenerate

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = mid0_w[AW-1:0];
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (search_acc) begin
					if (count_q != '0) begin
						rd_en   = 1'b1;
						state_d = ST_PROBE;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_PROBE: begin
				rd_addr = nmid_w[AW-1:0];
				if (nlo_w < nhi_w) begin
					rd_en = 1'b1;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_acc) begin
				if (start_req) begin
					count_q <= CW'(1);
				end else if (count_q < CW'(ARRAY_DEPTH)) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (search_acc) begin
			key_q   <= value;
			lo_q    <= '0;
			hi_q    <= count_q;
			hit_q   <= 1'b0;
			where_q <= '0;
			mid_s1  <= mid0_w[AW-1:0];
		end else if (state_q == ST_PROBE) begin
			lo_q   <= nlo_w;
			hi_q   <= nhi_w;
			mid_s1 <= nmid_w[AW-1:0];
			if (eq_w) begin
				hit_q   <= 1'b1;
				where_q <= mid_s1;
			end
		end
		if (load_out) begin
			found_q <= hit_q;
			pos_q   <= hit_q ? pos_w : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = pos_q;

endmodule

`default_nettype wire

[rtl/core/bsfm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsfm_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        mode,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        found,
	input wire logic [bsfm_pkg::POS_W-1:0]  position
);

	import bsfm_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(position))
		else $error("stalled result changed");

	// a miss reports index zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == '0)
		else $error("miss with nonzero position");

	// a search transfer blocks the input while the probes run
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_SEARCH |=> in_stall)
		else $error("input open during search");

	// a new result only comes out of a running search
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a search");

endmodule

bind binary_search_first_match bsfm_checker u_bsfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.found     (found),
	.position  (position)
);

`default_nettype wire

[bench/binary_search_first_match_test.sv]
`timescale 1ns / 1ps

module binary_search_first_match_test;
	import bsfm_pkg::*;

	localparam int DEPTH = 1024;

	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  position;
	} match_t;

	// Mirror of the loaded array; computes the lowest matching index per search.
	class sorted_array_model;
		logic signed [WORD_W-1:0] words [DEPTH];
		int unsigned count;
		match_t awaited_matches [$];
		int mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function void note_transfer(logic m, logic signed [WORD_W-1:0] v, logic s);
			int lo;
			int hi;
			int mid;
			match_t hit;
			if (m == MODE_LOAD) begin
				if (s)
					count = 0;
				// drop the word when the array is full
				if (count < DEPTH) begin
					words[count] = v;
					count++;
				end
			end else begin
				lo = 0;
				hi = int'(count) - 1;
				hit = '0;
				while (lo <= hi) begin
					mid = lo + (hi - lo) / 2;
					if (words[mid] == v) begin
						hit.found = 1'b1;
						hit.position = POS_W'(mid);
						hi = mid - 1;
					end else if (v < words[mid]) begin
						hi = mid - 1;
					end else begin
						lo = mid + 1;
					end
				end
				awaited_matches.push_back(hit);
			end
		endfunction

		function void check_result(logic f, logic [POS_W-1:0] p);
			match_t want;
			if (awaited_matches.size() == 0) begin
				$error("result with no search pending: found=%0d position=%0d", f, p);
				mismatches++;
				return;
			end
			want = awaited_matches.pop_front();
			if (f !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, f);
				mismatches++;
			end
			if (p !== want.position) begin
				$error("position: expected %0d, got %0d", want.position, p);
				mismatches++;
			end
		endfunction

		function int pending();
			return awaited_matches.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     mode;
	logic signed [WORD_W-1:0] value;
	logic                     start_req;
	logic                     out_valid;
	logic                     out_stall;
	logic                     found;
	logic [POS_W-1:0]         position;

	sorted_array_model model = new();
	logic signed [WORD_W-1:0] pool [$];
	int items_sent = 0;
	int sender_quiet = 0;
	bit full_done = 0;

	binary_search_first_match #(
		.ARRAY_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.value(value),
		.start_req(start_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.position(position)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Mostly short gaps, a few long ones, and now and then a stretch with none.
	function automatic int gap_length(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	task automatic send_item(input logic m, input logic signed [WORD_W-1:0] v, input logic s);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		start_req <= s;
		do
			@(posedge clk);
		while (in_stall);
		if (!(m == MODE_LOAD && !s && model.count >= DEPTH))
			items_sent++;
		model.note_transfer(m, v, s);
		// keep valid high when the next transfer follows at once
		gap = gap_length(sender_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic search_run(input int n);
		logic signed [WORD_W-1:0] key;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (pool.size() == 0 || r >= 8) begin
				key = $urandom;
			end else begin
				key = pool[$urandom_range(0, pool.size() - 1)];
				if (r == 6)
					key = key + 1;
				else if (r == 7)
					key = key - 1;
			end
			send_item(MODE_SEARCH, key, $urandom_range(0, 1));
		end
	endtask

	task automatic load_run(input int n, input bit sorted, input bit fresh);
		longint level;
		int unsigned spread;
		logic signed [WORD_W-1:0] word;
		logic restart;
		case ($urandom_range(0, 5))
			0: spread = 0;
			1: spread = 1;
			2: spread = 3;
			3: spread = 100;
			4: spread = 1 << 20;
			default: spread = 1 << 28;
		endcase
		if (n > 500)
			spread = 3;
		level = ($urandom_range(0, 7) == 0) ? -64'sd2147483648 : longint'($signed($urandom));
		for (int i = 0; i < n; i++) begin
			if (!sorted)
				word = $urandom;
			else if (level > 64'sd2147483647)
				word = 32'sh7fff_ffff;
			else
				word = level[WORD_W-1:0];
			restart = (fresh && i == 0) || (n <= 500 && $urandom_range(0, 59) == 0);
			if (restart)
				pool.delete();
			pool.push_back(word);
			send_item(MODE_LOAD, word, restart);
			level += $urandom_range(0, spread);
			if ($urandom_range(0, 24) == 0)
				search_run(1);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			model.check_result(found, position);
	end

	initial begin : sink
		int n;
		int quiet;
		quiet = 0;
		out_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = gap_length(quiet);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	end

	initial begin : source
		int r;
		int size;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_LOAD;
		value <= '0;
		start_req <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty array
		send_item(MODE_SEARCH, 32'sd0, 1'b0);

		// sorted with duplicates and both extremes
		send_item(MODE_LOAD, 32'sh8000_0000, 1'b1);
		send_item(MODE_LOAD, -32'sd1, 1'b0);
		send_item(MODE_LOAD, 32'sd0, 1'b0);
		send_item(MODE_LOAD, 32'sd0, 1'b0);
		send_item(MODE_LOAD, 32'sd0, 1'b0);
		send_item(MODE_LOAD, 32'sd1, 1'b0);
		send_item(MODE_LOAD, 32'sh7fff_ffff, 1'b0);
		send_item(MODE_SEARCH, 32'sh8000_0000, 1'b0);
		send_item(MODE_SEARCH, 32'sh7fff_ffff, 1'b0);
		send_item(MODE_SEARCH, 32'sd0, 1'b1);
		send_item(MODE_SEARCH, -32'sd1, 1'b0);
		send_item(MODE_SEARCH, 32'sd5, 1'b0);
		send_item(MODE_SEARCH, -32'sd5, 1'b1);

		// unsorted contents
		send_item(MODE_LOAD, 32'sd5, 1'b1);
		send_item(MODE_LOAD, 32'sd3, 1'b0);
		send_item(MODE_LOAD, 32'sd9, 1'b0);
		send_item(MODE_LOAD, 32'sd1, 1'b0);
		send_item(MODE_SEARCH, 32'sd3, 1'b0);
		send_item(MODE_SEARCH, 32'sd1, 1'b0);
		send_item(MODE_SEARCH, 32'sd9, 1'b0);
		send_item(MODE_SEARCH, 32'sd5, 1'b0);

		// single element
		send_item(MODE_LOAD, 32'sd7, 1'b1);
		send_item(MODE_SEARCH, 32'sd7, 1'b0);
		send_item(MODE_SEARCH, 32'sd8, 1'b0);

		while (items_sent < 850) begin
			if (!full_done) begin
				// fill past capacity, search deep indices, then restart while full
				load_run(DEPTH + 3, 1'b1, 1'b1);
				search_run(30);
				load_run(3, 1'b1, 1'b1);
				search_run(3);
				full_done = 1;
			end else begin
				r = $urandom_range(0, 19);
				if (r < 14)
					size = $urandom_range(1, 12);
				else if (r < 19)
					size = $urandom_range(13, 60);
				else
					size = $urandom_range(61, 250);
				load_run(size, $urandom_range(0, 7) != 0, $urandom_range(0, 5) != 0);
				search_run($urandom_range(2, 10));
			end
		end
		in_valid <= 1'b0;

		while (model.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (model.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
